/* design/flt_pkg.sv */
// shared types, codes and constants of the field line tracer step
package flt_pkg;

    localparam int POS_W = 20;

    localparam logic [2:0] STATUS_STEPPED    = 3'd0;
    localparam logic [2:0] STATUS_NEAR       = 3'd1;
    localparam logic [2:0] STATUS_OUTSIDE    = 3'd2;
    localparam logic [2:0] STATUS_ZERO_FIELD = 3'd3;
    localparam logic [2:0] STATUS_ADDED      = 3'd4;
    localparam logic [2:0] STATUS_FULL       = 3'd5;

    localparam logic [1:0] REG_AREA_WIDTH   = 2'd0;
    localparam logic [1:0] REG_AREA_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_PROBE_RADIUS = 2'd2;

    localparam logic [10:0] AREA_WIDTH_RST   = 11'd1440;
    localparam logic [10:0] AREA_HEIGHT_RST  = 11'd900;
    localparam logic [6:0]  PROBE_RADIUS_RST = 7'd5;

    typedef struct packed {
        logic               mode;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic               charge_pos;
        logic               backward;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [19:0] next_x;
        logic signed [19:0] next_y;
    } result_t;

    typedef struct packed {
        logic [10:0] area_width;
        logic [10:0] area_height;
        logic [6:0]  probe_radius;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ADD,
        OP_START,
        OP_READ,
        OP_VEC,
        OP_SQ1,
        OP_SQ2,
        OP_SQSUM,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_INV_INIT,
        OP_DIV_STEP,
        OP_INV_SAVE,
        OP_U_INIT,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ACC,
        OP_NEXT,
        OP_MAG,
        OP_NORM,
        OP_D_MUL,
        OP_D_INIT,
        OP_D_SAVE
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       sel_y;
        logic       fin;
        logic       capture;
        logic       load_out;
        logic [2:0] status;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic area_ok;
        logic full;
        logic near;
        logic idx_end;
        logic cnt_last;
        logic zero_field;
        logic norm_ok;
    } flags_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOOPCHK,
        ST_READ,
        ST_VEC,
        ST_SQ1,
        ST_SQ2,
        ST_SQSUM,
        ST_NEAR,
        ST_SQRT,
        ST_INV_INIT,
        ST_INV_DIV,
        ST_INV_SAVE,
        ST_U_INIT,
        ST_U_DIV,
        ST_U_LO,
        ST_U_HI,
        ST_U_ACC,
        ST_NEXT,
        ST_MAG,
        ST_NORM,
        ST_F_SQ1,
        ST_F_SQ2,
        ST_F_SQSUM,
        ST_F_SQRT_INIT,
        ST_F_SQRT,
        ST_D_MUL,
        ST_D_INIT,
        ST_D_DIV,
        ST_D_SAVE,
        ST_DONE
    } state_t;

endpackage

/* design/flt_regs.sv */
// configuration register file behind the apb port
module flt_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output flt_pkg::cfg_t       cfg
);

    flt_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.area_width   <= flt_pkg::AREA_WIDTH_RST;
            cfg_reg.area_height  <= flt_pkg::AREA_HEIGHT_RST;
            cfg_reg.probe_radius <= flt_pkg::PROBE_RADIUS_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                flt_pkg::REG_AREA_WIDTH:   cfg_reg.area_width   <= pwdata[10:0];
                flt_pkg::REG_AREA_HEIGHT:  cfg_reg.area_height  <= pwdata[10:0];
                flt_pkg::REG_PROBE_RADIUS: cfg_reg.probe_radius <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            flt_pkg::REG_AREA_WIDTH:   prdata = 32'(cfg_reg.area_width);
            flt_pkg::REG_AREA_HEIGHT:  prdata = 32'(cfg_reg.area_height);
            flt_pkg::REG_PROBE_RADIUS: prdata = 32'(cfg_reg.probe_radius);
            default:                   prdata = '0;
        endcase
    end

endmodule

/* design/flt_dp.sv */
// datapath: charge store, shared multiplier, divider, square root and accumulators
module flt_dp #(
    parameter int MAX_CHARGES = 64,
    parameter int FRAC_BITS   = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  flt_pkg::item_t   item,
    input  flt_pkg::cfg_t    cfg,
    input  flt_pkg::cmd_t    cmd,
    output flt_pkg::flags_t  flags,
    output flt_pkg::result_t result
);

    localparam int IW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
    localparam int CW = $clog2(MAX_CHARGES + 1);
    localparam int EW = 38 + IW;
    localparam int QD = 8 + FRAC_BITS;
    localparam int DD_W = 38 + FRAC_BITS;
    localparam int INV_Q = 37;
    localparam int UNIT_Q = 25;
    localparam int SQRT_STEPS = 31;

    logic signed [19:0] x_reg, y_reg;
    logic               mode_reg, cpos_reg, backward_reg;
    logic [CW-1:0]      count_reg, idx_reg;
    logic [40:0]        store [MAX_CHARGES];
    logic [40:0]        rd_reg;
    logic [20:0]        ax_reg, ay_reg;
    logic               vxn_reg, vyn_reg, sgn_reg;
    logic [59:0]        prod_reg, p0_reg;
    logic [61:0]        sq_reg;
    logic [61:0]        sqv_reg, sqres_reg, sqbit_reg;
    logic [41:0]        rem_reg, dvs_reg;
    logic [36:0]        low_reg, quo_reg, inv_reg;
    logic [5:0]         cnt_reg;
    logic signed [EW-1:0] ex_reg, ey_reg;
    logic [EW-2:0]      mx_reg, my_reg;
    logic signed [19:0] resx_reg, resy_reg;
    flt_pkg::result_t   out_reg;

    logic [29:0]        mul_a, mul_b;
    logic [59:0]        prod;
    logic [6:0]         r_eff;
    logic [13:0]        rsq;
    logic [61:0]        r2;
    logic signed [33:0] sx, sy, lim_x, lim_y;
    logic [42:0]        div_t, div_diff;
    logic               div_ge;
    logic [61:0]        sq_t;
    logic               sq_ge;
    logic [61:0]        acc_full;
    logic signed [EW-1:0] term;
    logic               term_neg;
    logic signed [20:0] vx, vy;
    logic [20:0]        u_src;
    logic [DD_W-1:0]    dividend;
    logic [30:0]        nrm;
    logic signed [21:0] base, dxs, nsum;
    logic signed [19:0] nsat;
    logic               step_neg;

    assign r_eff = (cfg.probe_radius == '0) ? 7'd1 : cfg.probe_radius;
    assign rsq   = 14'(r_eff) * 14'(r_eff);
    assign r2    = 62'(rsq) << (2 * FRAC_BITS);

    assign sx    = 34'(x_reg);
    assign sy    = 34'(y_reg);
    assign lim_x = $signed(34'(cfg.area_width) << FRAC_BITS);
    assign lim_y = $signed(34'(cfg.area_height) << FRAC_BITS);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            flt_pkg::OP_SQ1:
            begin
                mul_a = cmd.fin ? mx_reg[29:0] : 30'(ax_reg);
                mul_b = cmd.fin ? mx_reg[29:0] : 30'(ax_reg);
            end
            flt_pkg::OP_SQ2:
            begin
                mul_a = cmd.fin ? my_reg[29:0] : 30'(ay_reg);
                mul_b = cmd.fin ? my_reg[29:0] : 30'(ay_reg);
            end
            flt_pkg::OP_MUL_LO:
            begin
                mul_a = 30'(quo_reg[24:0]);
                mul_b = 30'(inv_reg[18:0]);
            end
            flt_pkg::OP_MUL_HI:
            begin
                mul_a = 30'(quo_reg[24:0]);
                mul_b = 30'(inv_reg[36:19]);
            end
            flt_pkg::OP_D_MUL:
            begin
                mul_a = cmd.sel_y ? my_reg[29:0] : mx_reg[29:0];
                mul_b = 30'(r_eff);
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // one quotient bit per step
    assign div_t    = {rem_reg, low_reg[36]};
    assign div_ge   = div_t >= {1'b0, dvs_reg};
    assign div_diff = div_t - {1'b0, dvs_reg};

    // one root bit per step
    assign sq_t  = sqres_reg + sqbit_reg;
    assign sq_ge = sqv_reg >= sq_t;

    assign acc_full = 62'(p0_reg) + (62'(prod_reg) << 19);
    assign term     = $signed(EW'(acc_full[60:24]));
    assign term_neg = (cmd.sel_y ? vyn_reg : vxn_reg) ^ ~sgn_reg;

    assign vx    = 21'(x_reg) - 21'($signed(rd_reg[40:21]));
    assign vy    = 21'(y_reg) - 21'($signed(rd_reg[20:1]));
    assign u_src = cmd.sel_y ? ay_reg : ax_reg;

    assign nrm      = sqres_reg[30:0];
    assign dividend = (DD_W'(prod_reg[36:0]) << FRAC_BITS) + DD_W'(nrm);

    assign base     = cmd.sel_y ? 22'(y_reg) : 22'(x_reg);
    assign dxs      = $signed(22'(quo_reg[QD-1:0]));
    assign step_neg = (cmd.sel_y ? ey_reg[EW-1] : ex_reg[EW-1]) ^ backward_reg;
    assign nsum     = step_neg ? base - dxs : base + dxs;

    always_comb
    begin
        if (nsum > 22'sd524287)
        begin
            nsat = 20'sd524287;
        end
        else if (nsum < -22'sd524288)
        begin
            nsat = -20'sd524288;
        end
        else
        begin
            nsat = nsum[19:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.op == flt_pkg::OP_ADD)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == flt_pkg::OP_ADD)
        begin
            store[count_reg[IW-1:0]] <= {x_reg, y_reg, cpos_reg};
        end
        if (cmd.op == flt_pkg::OP_READ)
        begin
            rd_reg <= store[idx_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg        <= item.pos_x;
            y_reg        <= item.pos_y;
            mode_reg     <= item.mode;
            cpos_reg     <= item.charge_pos;
            backward_reg <= item.backward;
            resx_reg     <= item.pos_x;
            resy_reg     <= item.pos_y;
        end
        if (cmd.load_out)
        begin
            out_reg.status <= cmd.status;
            out_reg.next_x <= resx_reg;
            out_reg.next_y <= resy_reg;
        end
        case (cmd.op)
            flt_pkg::OP_START:
            begin
                idx_reg <= '0;
                ex_reg  <= '0;
                ey_reg  <= '0;
            end
            flt_pkg::OP_VEC:
            begin
                ax_reg  <= vx[20] ? 21'(-vx) : 21'(vx);
                ay_reg  <= vy[20] ? 21'(-vy) : 21'(vy);
                vxn_reg <= vx[20];
                vyn_reg <= vy[20];
                sgn_reg <= rd_reg[0];
            end
            flt_pkg::OP_SQ1:
            begin
                prod_reg <= prod;
            end
            flt_pkg::OP_SQ2:
            begin
                sq_reg   <= 62'(prod_reg);
                prod_reg <= prod;
            end
            flt_pkg::OP_SQSUM:
            begin
                sq_reg <= sq_reg + 62'(prod_reg);
            end
            flt_pkg::OP_SQRT_INIT:
            begin
                sqv_reg   <= sq_reg;
                sqres_reg <= '0;
                sqbit_reg <= 62'(1) << 60;
                cnt_reg   <= 6'(SQRT_STEPS);
            end
            flt_pkg::OP_SQRT_STEP:
            begin
                if (sq_ge)
                begin
                    sqv_reg   <= sqv_reg - sq_t;
                    sqres_reg <= (sqres_reg >> 1) + sqbit_reg;
                end
                else
                begin
                    sqres_reg <= sqres_reg >> 1;
                end
                sqbit_reg <= sqbit_reg >> 2;
                cnt_reg   <= cnt_reg - 1'b1;
            end
            flt_pkg::OP_INV_INIT:
            begin
                rem_reg <= 42'(1) << (2 * FRAC_BITS - 1);
                low_reg <= '0;
                dvs_reg <= sq_reg[41:0];
                quo_reg <= '0;
                cnt_reg <= 6'(INV_Q);
            end
            flt_pkg::OP_DIV_STEP:
            begin
                rem_reg <= div_ge ? div_diff[41:0] : div_t[41:0];
                low_reg <= low_reg << 1;
                quo_reg <= {quo_reg[35:0], div_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            flt_pkg::OP_INV_SAVE:
            begin
                inv_reg <= quo_reg;
            end
            flt_pkg::OP_U_INIT:
            begin
                rem_reg <= 42'(u_src >> 1);
                low_reg <= {u_src[0], 36'b0};
                dvs_reg <= 42'(sqres_reg[20:0]);
                quo_reg <= '0;
                cnt_reg <= 6'(UNIT_Q);
            end
            flt_pkg::OP_MUL_LO:
            begin
                prod_reg <= prod;
            end
            flt_pkg::OP_MUL_HI:
            begin
                p0_reg   <= prod_reg;
                prod_reg <= prod;
            end
            flt_pkg::OP_ACC:
            begin
                if (cmd.sel_y)
                begin
                    ey_reg <= term_neg ? ey_reg - term : ey_reg + term;
                end
                else
                begin
                    ex_reg <= term_neg ? ex_reg - term : ex_reg + term;
                end
            end
            flt_pkg::OP_NEXT:
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            flt_pkg::OP_MAG:
            begin
                mx_reg <= ex_reg[EW-1] ? (EW-1)'(-ex_reg) : (EW-1)'(ex_reg);
                my_reg <= ey_reg[EW-1] ? (EW-1)'(-ey_reg) : (EW-1)'(ey_reg);
            end
            flt_pkg::OP_NORM:
            begin
                mx_reg <= mx_reg >> 1;
                my_reg <= my_reg >> 1;
            end
            flt_pkg::OP_D_MUL:
            begin
                prod_reg <= prod;
            end
            flt_pkg::OP_D_INIT:
            begin
                rem_reg <= 42'(dividend >> QD);
                low_reg <= 37'(dividend[QD-1:0]) << (37 - QD);
                dvs_reg <= 42'({nrm, 1'b0});
                quo_reg <= '0;
                cnt_reg <= 6'(QD);
            end
            flt_pkg::OP_D_SAVE:
            begin
                if (cmd.sel_y)
                begin
                    resy_reg <= nsat;
                end
                else
                begin
                    resx_reg <= nsat;
                end
            end
            default: ;
        endcase
    end

    assign flags.mode       = mode_reg;
    assign flags.area_ok    = (sx > 34'sd0) && (sx < lim_x) && (sy > 34'sd0) && (sy < lim_y);
    assign flags.full       = count_reg == CW'(MAX_CHARGES);
    assign flags.near       = sq_reg < r2;
    assign flags.idx_end    = idx_reg == count_reg;
    assign flags.cnt_last   = cnt_reg == 6'd1;
    assign flags.zero_field = (ex_reg == '0) && (ey_reg == '0);
    assign flags.norm_ok    = ((mx_reg >> 30) == '0) && ((my_reg >> 30) == '0);

    assign result = out_reg;

endmodule

/* design/flt_ctrl.sv */
// controller state machine sequencing the datapath
module flt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    output logic            result_valid,
    input  logic            result_ready,
    input  flt_pkg::flags_t flags,
    output flt_pkg::cmd_t   cmd
);

    flt_pkg::state_t state_reg, state_next;
    logic            sel_reg, sel_next;
    logic [2:0]      status_reg, status_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= flt_pkg::ST_IDLE;
            sel_reg       <= 1'b0;
            status_reg    <= flt_pkg::STATUS_STEPPED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        status_next = status_reg;
        item_ready  = 1'b0;
        cmd.op       = flt_pkg::OP_NONE;
        cmd.sel_y    = sel_reg;
        cmd.fin      = 1'b0;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        cmd.status   = status_reg;
        out_valid_next = out_valid_reg && !result_ready;

        unique case (state_reg)
            flt_pkg::ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
                if (item_valid)
                begin
                    state_next = flt_pkg::ST_DISPATCH;
                end
            end
            flt_pkg::ST_DISPATCH:
            begin
                state_next = flt_pkg::ST_DONE;
                if (!flags.mode)
                begin
                    if (flags.full)
                    begin
                        status_next = flt_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        cmd.op      = flt_pkg::OP_ADD;
                        status_next = flt_pkg::STATUS_ADDED;
                    end
                end
                else if (!flags.area_ok)
                begin
                    status_next = flt_pkg::STATUS_OUTSIDE;
                end
                else
                begin
                    cmd.op     = flt_pkg::OP_START;
                    state_next = flt_pkg::ST_LOOPCHK;
                end
            end
            flt_pkg::ST_LOOPCHK:
            begin
                if (!flags.idx_end)
                begin
                    state_next = flt_pkg::ST_READ;
                end
                else if (flags.zero_field)
                begin
                    status_next = flt_pkg::STATUS_ZERO_FIELD;
                    state_next  = flt_pkg::ST_DONE;
                end
                else
                begin
                    state_next = flt_pkg::ST_MAG;
                end
            end
            flt_pkg::ST_READ:
            begin
                cmd.op     = flt_pkg::OP_READ;
                state_next = flt_pkg::ST_VEC;
            end
            flt_pkg::ST_VEC:
            begin
                cmd.op     = flt_pkg::OP_VEC;
                state_next = flt_pkg::ST_SQ1;
            end
            flt_pkg::ST_SQ1:
            begin
                cmd.op     = flt_pkg::OP_SQ1;
                state_next = flt_pkg::ST_SQ2;
            end
            flt_pkg::ST_SQ2:
            begin
                cmd.op     = flt_pkg::OP_SQ2;
                state_next = flt_pkg::ST_SQSUM;
            end
            flt_pkg::ST_SQSUM:
            begin
                cmd.op     = flt_pkg::OP_SQSUM;
                state_next = flt_pkg::ST_NEAR;
            end
            flt_pkg::ST_NEAR:
            begin
                if (flags.near)
                begin
                    status_next = flt_pkg::STATUS_NEAR;
                    state_next  = flt_pkg::ST_DONE;
                end
                else
                begin
                    cmd.op     = flt_pkg::OP_SQRT_INIT;
                    state_next = flt_pkg::ST_SQRT;
                end
            end
            flt_pkg::ST_SQRT:
            begin
                cmd.op = flt_pkg::OP_SQRT_STEP;
                if (flags.cnt_last)
                begin
                    state_next = flt_pkg::ST_INV_INIT;
                end
            end
            flt_pkg::ST_INV_INIT:
            begin
                cmd.op     = flt_pkg::OP_INV_INIT;
                state_next = flt_pkg::ST_INV_DIV;
            end
            flt_pkg::ST_INV_DIV:
            begin
                cmd.op = flt_pkg::OP_DIV_STEP;
                if (flags.cnt_last)
                begin
                    state_next = flt_pkg::ST_INV_SAVE;
                end
            end
            flt_pkg::ST_INV_SAVE:
            begin
                cmd.op     = flt_pkg::OP_INV_SAVE;
                state_next = flt_pkg::ST_U_INIT;
            end
            flt_pkg::ST_U_INIT:
            begin
                cmd.op     = flt_pkg::OP_U_INIT;
                state_next = flt_pkg::ST_U_DIV;
            end
            flt_pkg::ST_U_DIV:
            begin
                cmd.op = flt_pkg::OP_DIV_STEP;
                if (flags.cnt_last)
                begin
                    state_next = flt_pkg::ST_U_LO;
                end
            end
            flt_pkg::ST_U_LO:
            begin
                cmd.op     = flt_pkg::OP_MUL_LO;
                state_next = flt_pkg::ST_U_HI;
            end
            flt_pkg::ST_U_HI:
            begin
                cmd.op     = flt_pkg::OP_MUL_HI;
                state_next = flt_pkg::ST_U_ACC;
            end
            flt_pkg::ST_U_ACC:
            begin
                cmd.op   = flt_pkg::OP_ACC;
                sel_next = !sel_reg;
                state_next = sel_reg ? flt_pkg::ST_NEXT : flt_pkg::ST_U_INIT;
            end
            flt_pkg::ST_NEXT:
            begin
                cmd.op     = flt_pkg::OP_NEXT;
                state_next = flt_pkg::ST_LOOPCHK;
            end
            flt_pkg::ST_MAG:
            begin
                cmd.op     = flt_pkg::OP_MAG;
                state_next = flt_pkg::ST_NORM;
            end
            flt_pkg::ST_NORM:
            begin
                if (flags.norm_ok)
                begin
                    state_next = flt_pkg::ST_F_SQ1;
                end
                else
                begin
                    cmd.op = flt_pkg::OP_NORM;
                end
            end
            flt_pkg::ST_F_SQ1:
            begin
                cmd.op     = flt_pkg::OP_SQ1;
                cmd.fin    = 1'b1;
                state_next = flt_pkg::ST_F_SQ2;
            end
            flt_pkg::ST_F_SQ2:
            begin
                cmd.op     = flt_pkg::OP_SQ2;
                cmd.fin    = 1'b1;
                state_next = flt_pkg::ST_F_SQSUM;
            end
            flt_pkg::ST_F_SQSUM:
            begin
                cmd.op     = flt_pkg::OP_SQSUM;
                cmd.fin    = 1'b1;
                state_next = flt_pkg::ST_F_SQRT_INIT;
            end
            flt_pkg::ST_F_SQRT_INIT:
            begin
                cmd.op     = flt_pkg::OP_SQRT_INIT;
                state_next = flt_pkg::ST_F_SQRT;
            end
            flt_pkg::ST_F_SQRT:
            begin
                cmd.op = flt_pkg::OP_SQRT_STEP;
                if (flags.cnt_last)
                begin
                    state_next = flt_pkg::ST_D_MUL;
                end
            end
            flt_pkg::ST_D_MUL:
            begin
                cmd.op     = flt_pkg::OP_D_MUL;
                state_next = flt_pkg::ST_D_INIT;
            end
            flt_pkg::ST_D_INIT:
            begin
                cmd.op     = flt_pkg::OP_D_INIT;
                state_next = flt_pkg::ST_D_DIV;
            end
            flt_pkg::ST_D_DIV:
            begin
                cmd.op = flt_pkg::OP_DIV_STEP;
                if (flags.cnt_last)
                begin
                    state_next = flt_pkg::ST_D_SAVE;
                end
            end
            flt_pkg::ST_D_SAVE:
            begin
                cmd.op   = flt_pkg::OP_D_SAVE;
                sel_next = !sel_reg;
                if (sel_reg)
                begin
                    status_next = flt_pkg::STATUS_STEPPED;
                    state_next  = flt_pkg::ST_DONE;
                end
                else
                begin
                    state_next = flt_pkg::ST_D_MUL;
                end
            end
            flt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = flt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = flt_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

`ifndef SYNTHESIS
    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || result_ready))
        else $error("result overwritten before transfer");

    // an accepted item always starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == flt_pkg::ST_DISPATCH))
        else $error("accepted item not dispatched");

    // a result appears only from the completion state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == flt_pkg::ST_DONE))
        else $error("result raised outside completion");

    // axis select is back on x whenever a new item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == flt_pkg::ST_IDLE) |-> !sel_reg)
        else $error("axis select left on y");
`endif

endmodule

/* design/field_line_tracer_step.sv */
// Field line tracer step: keeps a table of point charges and moves a probe
// point half the probe radius along or against their summed electric field.
// Items are taken one at a time. For each stored charge a full step runs the
// shared one-bit-a-cycle divider (37 + 2 x 25 steps) and the one-bit-a-cycle
// square root (31 steps); the field is then normalised and the step formed
// with a further square root and 2 x (FRAC_BITS + 8) divider steps. The result
// sits in an output register until its transfer; the next item is taken
// meanwhile.
module field_line_tracer_step #(
    parameter int MAX_CHARGES = 64,
    parameter int FRAC_BITS   = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  flt_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output flt_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    flt_pkg::cfg_t   cfg;
    flt_pkg::cmd_t   cmd;
    flt_pkg::flags_t flags;

    flt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    flt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .flags        (flags),
        .cmd          (cmd)
    );

    flt_dp #(
        .MAX_CHARGES (MAX_CHARGES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg),
        .cmd    (cmd),
        .flags  (flags),
        .result (result)
    );

endmodule
